// ===== rtl/chebyshev_series_evaluate_top_macros.svh =====
// Assertion macros for the Chebyshev series evaluator.
// Taken in by the top level; relies on clk and arst_n in scope.
`ifndef CHEBYSHEV_SERIES_EVALUATE_TOP_MACROS_SVH
`define CHEBYSHEV_SERIES_EVALUATE_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define CSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cse assertion failed");

// check cons in the cycle after ante
`define CSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cse assertion failed");

`endif

// ===== rtl/cse_pkg.sv =====
// Shared types, constants and microcode program of the Chebyshev series evaluator.
// No dependencies.
`timescale 1ns / 1ps

package cse_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] CFG_TERM_COUNT = 2'd2;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic              func;
		logic [3:0]        coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [31:0] x_value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] y_value;
		logic              range_error;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic [4:0]         term_count;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_MAP,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_SIGN,
		OP_READ,
		OP_FREAD,
		OP_ACC,
		OP_FINAL,
		OP_ERR
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_EVAL,
		COND_RANGE_ERR,
		COND_DIV_SAT,
		COND_CNT_NZ,
		COND_N_ONE,
		COND_IDX_GT1
	} cond_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		op_t   op;
		logic  hold;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic advance;
	} ctrl_t;

	typedef struct packed {
		logic no_eval;
		logic range_err;
		logic div_sat;
		logic cnt_nz;
		logic n_one;
		logic idx_gt1;
		logic out_free;
	} stat_t;

	localparam pc_t S_IDLE    = 4'd0;
	localparam pc_t S_MAP     = 4'd1;
	localparam pc_t S_DIVINIT = 4'd2;
	localparam pc_t S_DIVSTEP = 4'd3;
	localparam pc_t S_SIGN    = 4'd4;
	localparam pc_t S_LRD     = 4'd5;
	localparam pc_t S_LACC    = 4'd6;
	localparam pc_t S_FRD     = 4'd7;
	localparam pc_t S_FACC    = 4'd8;
	localparam pc_t S_ERR     = 4'd9;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			S_IDLE:    w = '{op: OP_IDLE,    hold: 1'b0, cond: COND_NO_EVAL,   target: S_IDLE};
			S_MAP:     w = '{op: OP_MAP,     hold: 1'b0, cond: COND_RANGE_ERR, target: S_ERR};
			S_DIVINIT: w = '{op: OP_DIVINIT, hold: 1'b0, cond: COND_DIV_SAT,   target: S_SIGN};
			S_DIVSTEP: w = '{op: OP_DIVSTEP, hold: 1'b0, cond: COND_CNT_NZ,    target: S_DIVSTEP};
			S_SIGN:    w = '{op: OP_SIGN,    hold: 1'b0, cond: COND_N_ONE,     target: S_FRD};
			S_LRD:     w = '{op: OP_READ,    hold: 1'b0, cond: COND_NEVER,     target: S_IDLE};
			S_LACC:    w = '{op: OP_ACC,     hold: 1'b0, cond: COND_IDX_GT1,   target: S_LRD};
			S_FRD:     w = '{op: OP_FREAD,   hold: 1'b0, cond: COND_NEVER,     target: S_IDLE};
			S_FACC:    w = '{op: OP_FINAL,   hold: 1'b1, cond: COND_ALWAYS,    target: S_IDLE};
			S_ERR:     w = '{op: OP_ERR,     hold: 1'b1, cond: COND_ALWAYS,    target: S_IDLE};
			default:   w = '{op: OP_IDLE,    hold: 1'b0, cond: COND_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/cse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/cse_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  cse_pkg::stat_t stat,
	output cse_pkg::ctrl_t ctrl
);

	cse_pkg::pc_t    pc_q;
	cse_pkg::pc_t    pc_d;
	cse_pkg::uword_t uw;
	logic            take;
	logic            advance;

	always_comb begin
		uw = cse_pkg::ucode(pc_q);
		unique case (uw.cond)
			cse_pkg::COND_NEVER:     take = 1'b0;
			cse_pkg::COND_ALWAYS:    take = 1'b1;
			cse_pkg::COND_NO_EVAL:   take = stat.no_eval;
			cse_pkg::COND_RANGE_ERR: take = stat.range_err;
			cse_pkg::COND_DIV_SAT:   take = stat.div_sat;
			cse_pkg::COND_CNT_NZ:    take = stat.cnt_nz;
			cse_pkg::COND_N_ONE:     take = stat.n_one;
			cse_pkg::COND_IDX_GT1:   take = stat.idx_gt1;
			default:                 take = 1'b0;
		endcase
		advance = !uw.hold || stat.out_free;
		priority if (!advance) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
		ctrl.op      = uw.op;
		ctrl.advance = advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cse_pkg::S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== rtl/cse_dp.sv =====
// Datapath: point mapping, bit-serial divider, Clenshaw multiply-accumulate, result register.
// Depends on cse_pkg and cse_ram.
`timescale 1ns / 1ps

module cse_dp #(
	parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cse_pkg::cfg_t       cfg,
	input  cse_pkg::ctrl_t      ctrl,
	output cse_pkg::stat_t      stat,
	input  logic                in_valid,
	output logic                in_stall,
	input  cse_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output cse_pkg::out_word_t  out_word
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	logic                in_acc;
	logic                load_we;
	logic [IW-1:0]       load_addr;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	logic [31:0]         rdata;

	logic [MAX_TERMS-1:0] valid_q;
	logic                 rvalid_q;
	logic                 out_valid_q;
	cse_pkg::out_word_t   out_word_q;

	logic signed [31:0]  x_q;
	logic signed [33:0]  num;
	logic signed [32:0]  den_full;
	logic                neg_q;
	logic [33:0]         mag_q;
	logic [31:0]         den_q;
	logic [63:0]         dwide;
	logic                sat_now;
	logic                sat_q;
	logic [31:0]         rem_q;
	logic [30:0]         dlo_q;
	logic [30:0]         quo_q;
	logic [4:0]          cnt_q;
	logic [32:0]         rsh;
	logic                ge;
	logic [31:0]         qmag;
	logic signed [31:0]  xs_q;
	logic signed [31:0]  b1_q;
	logic signed [31:0]  b2_q;
	logic signed [63:0]  prod_q;
	logic [IW-1:0]       idx_q;
	logic [6:0]          tc7;
	logic [6:0]          n7;
	logic [6:0]          nm1;
	logic signed [31:0]  coef;
	logic signed [63:0]  shp;
	logic signed [65:0]  sum;
	logic signed [31:0]  t_sat;
	logic                commit_y;
	logic                commit_err;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		priority if (v > 66'(cse_pkg::SAT_MAX)) begin
			r = cse_pkg::SAT_MAX;
		end else if (v < 66'(cse_pkg::SAT_MIN)) begin
			r = cse_pkg::SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign in_stall  = ctrl.op != cse_pkg::OP_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign load_we   = in_acc && !in_word.func && (int'(in_word.coeff_index) < MAX_TERMS);
	assign load_addr = IW'(in_word.coeff_index);
	assign rd_en     = ctrl.op == cse_pkg::OP_READ || ctrl.op == cse_pkg::OP_FREAD;
	assign rd_addr   = (ctrl.op == cse_pkg::OP_FREAD) ? '0 : idx_q;

	cse_ram #(
		.WIDTH(32),
		.DEPTH(MAX_TERMS)
	) u_coef_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(load_addr),
		.wdata(in_word.coeff_value),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		num      = (34'(x_q) <<< 1) - 34'(cfg.range_low) - 34'(cfg.range_high);
		den_full = 33'(cfg.range_high) - 33'(cfg.range_low);
		dwide    = 64'(mag_q) << FRAC_BITS;
		sat_now  = {30'b0, mag_q} >= (64'(den_q) << (31 - FRAC_BITS));
		rsh      = {rem_q, dlo_q[30]};
		ge       = rsh >= {1'b0, den_q};
		qmag     = sat_q ? 32'h8000_0000 : {1'b0, quo_q};
		tc7      = 7'(cfg.term_count);
		priority if (tc7 == 7'd0) begin
			n7 = 7'd1;
		end else if (tc7 > 7'(MAX_TERMS)) begin
			n7 = 7'(MAX_TERMS);
		end else begin
			n7 = tc7;
		end
		nm1  = n7 - 7'd1;
		coef = rvalid_q ? $signed(rdata) : '0;
		shp  = (ctrl.op == cse_pkg::OP_FINAL) ? (prod_q >>> FRAC_BITS)
		                                       : (prod_q >>> (FRAC_BITS - 1));
		sum   = 66'(coef) + 66'(shp) - 66'(b2_q);
		t_sat = sat32(sum);

		stat.no_eval   = !(in_acc && in_word.func);
		stat.range_err = cfg.range_high <= cfg.range_low;
		stat.div_sat   = sat_now;
		stat.cnt_nz    = cnt_q != 5'd0;
		stat.n_one     = n7 == 7'd1;
		stat.idx_gt1   = idx_q > IW'(1);
		stat.out_free  = !out_valid_q || !out_stall;

		commit_y   = ctrl.op == cse_pkg::OP_FINAL && ctrl.advance;
		commit_err = ctrl.op == cse_pkg::OP_ERR && ctrl.advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_we) begin
				valid_q[load_addr] <= 1'b1;
			end
			if (commit_y || commit_err) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rvalid_q <= valid_q[rd_addr];
			prod_q   <= xs_q * b1_q;
		end
		if (commit_y) begin
			out_word_q <= '{y_value: t_sat, range_error: 1'b0};
		end
		if (commit_err) begin
			out_word_q <= '{y_value: '0, range_error: 1'b1};
		end
		unique case (ctrl.op)
			cse_pkg::OP_IDLE: begin
				if (in_acc && in_word.func) begin
					x_q <= in_word.x_value;
				end
			end
			cse_pkg::OP_MAP: begin
				neg_q <= num[33];
				mag_q <= num[33] ? unsigned'(-num) : unsigned'(num);
				den_q <= den_full[31:0];
			end
			cse_pkg::OP_DIVINIT: begin
				sat_q <= sat_now;
				rem_q <= dwide[62:31];
				dlo_q <= dwide[30:0];
				quo_q <= '0;
				cnt_q <= 5'd30;
			end
			cse_pkg::OP_DIVSTEP: begin
				rem_q <= ge ? 32'(rsh - {1'b0, den_q}) : rsh[31:0];
				quo_q <= {quo_q[29:0], ge};
				dlo_q <= {dlo_q[29:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			cse_pkg::OP_SIGN: begin
				priority if (neg_q) begin
					xs_q <= $signed(-qmag);
				end else if (qmag[31]) begin
					xs_q <= cse_pkg::SAT_MAX;
				end else begin
					xs_q <= $signed(qmag);
				end
				b1_q  <= '0;
				b2_q  <= '0;
				idx_q <= nm1[IW-1:0];
			end
			cse_pkg::OP_ACC: begin
				b2_q  <= b1_q;
				b1_q  <= t_sat;
				idx_q <= idx_q - IW'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== rtl/chebyshev_series_evaluate_top.sv =====
// Top level of the Chebyshev series evaluator: configuration registers, sequencer, datapath.
// Depends on cse_pkg, cse_seq, cse_dp and the assertion macro header.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------
//  in      | input     | in_valid / in_stall   | cse_pkg::in_word_t
//  out     | output    | out_valid / out_stall | cse_pkg::out_word_t
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A load word is written to the table when it is taken. An evaluate word maps the point,
// skips the divider (31 steps, one bit per cycle) when the mapped point saturates, and
// takes a read and an accumulate step per coefficient on the shared multiplier.
// An empty interval goes straight to an error result.
// Reset clears the coefficient valid bits, so the table reads as zero until loaded.
// out_stall holds the final step; input is taken again once the result register is loaded.
`timescale 1ns / 1ps
`include "chebyshev_series_evaluate_top_macros.svh"

module chebyshev_series_evaluate_top #(
	parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cse_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output cse_pkg::out_word_t out_word
);

	cse_pkg::cfg_t  cfg_q;
	cse_pkg::ctrl_t ctrl;
	cse_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low  <= 32'sd0;
			cfg_q.range_high <= 32'sd65536;
			cfg_q.term_count <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cse_pkg::CFG_RANGE_LOW:  cfg_q.range_low  <= $signed(cfg_data);
				cse_pkg::CFG_RANGE_HIGH: cfg_q.range_high <= $signed(cfg_data);
				cse_pkg::CFG_TERM_COUNT: cfg_q.term_count <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	cse_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	cse_dp #(
		.MAX_TERMS(MAX_TERMS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.ctrl     (ctrl),
		.stat     (stat),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	`CSE_ASSERT_NOW(a_commit_slot_free, ((ctrl.op == cse_pkg::OP_FINAL || ctrl.op == cse_pkg::OP_ERR) && ctrl.advance), (!out_valid || !out_stall))
	`CSE_ASSERT_NOW(a_err_zero, (out_valid && out_word.range_error), (out_word.y_value == 32'sd0))
	`CSE_ASSERT_NEXT(a_div_exit, (ctrl.op == cse_pkg::OP_DIVSTEP), (ctrl.op == cse_pkg::OP_DIVSTEP || ctrl.op == cse_pkg::OP_SIGN))

endmodule

// ===== sim/tb_chebyshev_series_evaluate_top.sv =====
`timescale 1ns / 1ps
// Testbench for chebyshev_series_evaluate_top: a directed table, then random load and evaluate
// words under several interval and term settings, checked against typed rows or a Clenshaw model.
// Depends on cse_pkg and the evaluator RTL.

module tb_chebyshev_series_evaluate_top;
	import cse_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int TERMS = MAX_TERMS_DEF;
	localparam int SETTLE = 80;
	localparam int HOLD_CYCLES = 400;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [31:0] val;
		logic [3:0]  idx;
		logic [31:0] x;
		logic        typed;
		logic [31:0] want_y;
		logic        want_err;
	} row_t;

	localparam row_t DIRECTED [32] = '{
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h7FFF_FFFF, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h8000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_8000, 1'b1, 32'h8000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h0001_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h0002_0000, 4'd1,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'hFFFF_8000, 4'd2,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h7FFF_FFFF, 4'd15, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_TERM_COUNT, 32'd3,         4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_4000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_TERM_COUNT, 32'd16,        4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_TERM_COUNT, 32'd0,         4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_3039, 1'b1, 32'h0001_0000, 1'b0},
		'{ROW_CFG,  CFG_TERM_COUNT, 32'd31,        4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_9C40, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_RANGE_HIGH, 32'h0000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
		'{ROW_CFG,  CFG_RANGE_LOW,  32'h7FFF_FFFF, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_RANGE_HIGH, 32'h8000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1},
		'{ROW_CFG,  CFG_RANGE_LOW,  32'h8000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  CFG_RANGE_HIGH, 32'h7FFF_FFFF, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, CFG_RANGE_LOW,  32'h8000_0000, 4'd15, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, CFG_RANGE_LOW,  32'h0000_0000, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;

	logic signed [31:0] coef_tbl [TERMS];
	logic signed [31:0] p_lo;
	logic signed [31:0] p_hi;
	logic [4:0]         p_terms;
	out_word_t          results_due [$];
	out_word_t          due_word;
	int                 bad_words = 0;
	bit                 tx_calm = 1'b0;
	bit                 squeeze_req = 1'b0;

	chebyshev_series_evaluate_top uut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_stall,
		.in_word,
		.out_valid,
		.out_stall,
		.out_word
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > longint'(SAT_MAX))
			return longint'(SAT_MAX);
		if (v < longint'(SAT_MIN))
			return longint'(SAT_MIN);
		return v;
	endfunction

	function automatic out_word_t clenshaw_eval(input logic signed [31:0] x);
		out_word_t          r;
		longint             num;
		longint unsigned    den;
		longint unsigned    mag;
		longint unsigned    q;
		longint             xs;
		longint             b1;
		longint             b2;
		longint             t;
		int                 n;
		r = '0;
		if (p_hi <= p_lo) begin
			r.range_error = 1'b1;
			return r;
		end
		num = 2 * longint'(x) - (longint'(p_lo) + longint'(p_hi));
		den = longint'(p_hi) - longint'(p_lo);
		mag = (num < 0) ? -num : num;
		q = (mag << FRAC) / den;
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		xs = clamp32((num < 0) ? -longint'(q) : longint'(q));
		n = p_terms;
		if (n < 1)
			n = 1;
		if (n > TERMS)
			n = TERMS;
		b1 = 0;
		b2 = 0;
		for (int k = n - 1; k >= 1; k--) begin
			t = clamp32(longint'(coef_tbl[k]) + ((xs * b1) >>> (FRAC - 1)) - b2);
			b2 = b1;
			b1 = t;
		end
		r.y_value = 32'(clamp32(longint'(coef_tbl[0]) + ((xs * b1) >>> FRAC) - b2));
		return r;
	endfunction

	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t random_word();
		in_word_t        w;
		int unsigned     r;
		longint          span;
		longint unsigned off;
		w.func = ($urandom_range(0, 99) < 40) ? FUNC_LOAD : FUNC_EVAL;
		w.coeff_index = 4'($urandom_range(0, 15));
		w.coeff_value = $urandom;
		w.x_value = $urandom;
		r = $urandom_range(0, 99);
		if (w.func == FUNC_LOAD) begin
			if (r < 80)
				w.coeff_value = int'($urandom_range(0, 1 << 19)) - (1 << 18);
			else if (r < 88)
				w.coeff_value = r[0] ? SAT_MAX : SAT_MIN;
		end else if (r < 75 && p_hi > p_lo) begin
			span = longint'(p_hi) - longint'(p_lo);
			off = {$urandom, $urandom} % (span + 1);
			w.x_value = 32'(longint'(p_lo) + longint'(off));
		end else if (r < 85) begin
			w.x_value = r[0] ? p_lo : p_hi;
		end else if (r < 91) begin
			w.x_value = r[0] ? SAT_MAX : SAT_MIN;
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input bit rush, input bit typed,
			input out_word_t want);
		int gap;
		gap = (rush || tx_calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if ($urandom_range(0, 49) == 0)
			tx_calm = !tx_calm;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall);
		if (w.func == FUNC_LOAD)
			coef_tbl[w.coeff_index] = w.coeff_value;
		else
			results_due.push_back(typed ? want : clenshaw_eval(w.x_value));
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RANGE_LOW:  p_lo = d;
			CFG_RANGE_HIGH: p_hi = d;
			CFG_TERM_COUNT: p_terms = d[4:0];
			default: ;
		endcase
	endtask

	task automatic random_interval(output logic signed [31:0] lo, output logic signed [31:0] hi);
		logic signed [31:0] a;
		logic signed [31:0] b;
		a = $urandom;
		b = $urandom;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
	endtask

	task automatic run_phase(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic [4:0] tc, input int count, input bit squeeze);
		quiesce();
		write_cfg(CFG_RANGE_LOW, lo);
		write_cfg(CFG_RANGE_HIGH, hi);
		write_cfg(CFG_TERM_COUNT, {27'd0, tc});
		if (squeeze)
			squeeze_req = 1'b1;
		for (int i = 0; i < count; i++)
			send_word(random_word(), squeeze && i < 30, 1'b0, '0);
	endtask

	// receiver back-pressure, with one long hold when requested
	initial begin
		int stall_left;
		bit rx_calm;
		stall_left = 0;
		rx_calm = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (squeeze_req) begin
					stall_left = HOLD_CYCLES;
					squeeze_req = 1'b0;
				end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
				if ($urandom_range(0, 99) == 0)
					rx_calm = !rx_calm;
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected word: y=%h err=%b", out_word.y_value,
						out_word.range_error);
			end else begin
				due_word = results_due.pop_front();
				if (out_word.y_value !== due_word.y_value ||
						out_word.range_error !== due_word.range_error) begin
					bad_words++;
					if (bad_words <= 10)
						$display("mismatch: y=%h err=%b, expected y=%h err=%b",
							out_word.y_value, out_word.range_error,
							due_word.y_value, due_word.range_error);
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t               row;
		in_word_t           w;
		out_word_t          want;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RANGE_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		for (int i = 0; i < TERMS; i++)
			coef_tbl[i] = '0;
		p_lo = 32'sd0;
		p_hi = 32'sd65536;
		p_terms = 5'd1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				quiesce();
				write_cfg(row.reg_idx, row.val);
			end else begin
				w.func = (row.kind == ROW_LOAD) ? FUNC_LOAD : FUNC_EVAL;
				w.coeff_index = row.idx;
				w.coeff_value = row.val;
				w.x_value = row.x;
				want.y_value = row.want_y;
				want.range_error = row.want_err;
				send_word(w, 1'b0, row.typed, want);
			end
		end

		run_phase(-32'sd65536, 32'sd65536, 5'd8, 130, 1'b0);
		run_phase(32'sd0, 32'sd65536, 5'd16, 130, 1'b1);
		random_interval(lo, hi);
		run_phase(lo, hi, 5'($urandom_range(1, 16)), 130, 1'b0);
		run_phase(SAT_MIN, SAT_MAX, 5'd16, 120, 1'b0);
		random_interval(lo, hi);
		run_phase(hi, lo, 5'($urandom_range(0, 31)), 40, 1'b0);
		run_phase(32'sd1000, 32'sd1001, 5'd5, 120, 1'b0);
		random_interval(lo, hi);
		run_phase(lo, hi, 5'($urandom_range(0, 31)), 140, 1'b0);
		random_interval(lo, hi);
		run_phase(lo, hi, 5'd16, 140, 1'b0);
		quiesce();

		if (bad_words == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== chebyshev_series_evaluate_top.f =====
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/cse_seq.sv
rtl/cse_dp.sv
rtl/chebyshev_series_evaluate_top.sv
sim/tb_chebyshev_series_evaluate_top.sv
